@@ hdl/mtg_pkg.sv @@
// Shared constants and command codes for the Mersenne twister generator.
package mtg_pkg;

  // State store geometry
  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = 10;
  localparam int unsigned WORD_W       = 32;

  // Generator constants
  localparam logic [WORD_W-1:0] MAT_A        = 32'h9908b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;
  localparam logic [WORD_W-1:0] LCG_MUL      = 32'd69069;
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd4357;
  localparam logic [WORD_W-1:0] HALF_MASK    = 32'hffff0000;

  // Index values with a special meaning
  localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(STATE_WORDS - 1);
  localparam logic [IDX_W-1:0] IDX_SPENT    = IDX_W'(STATE_WORDS);
  localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_WORDS + 1);

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_RESEED = 2'd1,
    CMD_LOAD   = 2'd2
  } cmd_e;

endpackage

@@ hdl/mtg_ram.sv @@
// Generic RAM: one write port, two registered read ports.
module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and registered reads
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

@@ hdl/mersenne_twister_generator.sv @@
// MT19937 generator top level: command sequencer, state store and tempering.
// Usage: each input beat carries a command. A load writes the state word at the
// load pointer; the 624th load arms the generator. A reseed fills all 624 words
// from the seed register with the 69069 linear-congruential initializer, word by
// word through states SEED_HI and SEED_LO (one LCG multiplier used twice per
// word). A draw passes from acceptance through a read state and an output state,
// which waits for a free output register, into the result register when state
// words remain; when they are spent, the whole state is twisted in place first,
// through a read state and a write state for each word of the two-read-port state
// memory. A draw before any seeding self-seeds with 4357 first. The block takes
// one command at a time and holds in_stall_o high until that command is done; a
// finished result waits in the output register while the next command is
// accepted. Unused command code 3 is accepted and does nothing.
module mersenne_twister_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mtg_pkg::WORD_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                cmd_i,
  input  logic [mtg_pkg::WORD_W-1:0] load_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mtg_pkg::WORD_W-1:0] random_word_o
);
  import mtg_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE        = 8'b0000_0001,
    S_SEED_HI     = 8'b0000_0010,
    S_SEED_LO     = 8'b0000_0100,
    S_TWIST_PRIME = 8'b0000_1000,
    S_TWIST_RD    = 8'b0001_0000,
    S_TWIST_WR    = 8'b0010_0000,
    S_DRAW_RD     = 8'b0100_0000,
    S_DRAW_OUT    = 8'b1000_0000
  } state_e;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] y;
    y = x;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  state_e            state_q, state_d;
  logic [WORD_W-1:0] seed_q;
  logic [IDX_W-1:0]  word_idx_q, word_idx_d;
  logic [IDX_W-1:0]  load_ptr_q, load_ptr_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;
  logic [WORD_W-1:0] lcg_q, lcg_d;
  logic [WORD_W-1:0] hi_word_q, hi_word_d;
  logic              hi_bit_q, hi_bit_d;
  logic              draw_pend_q, draw_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_data_q, out_data_d;

  logic              in_accept;
  logic              out_free;
  logic [WORD_W-1:0] lcg_next;
  logic [IDX_W-1:0]  next_idx;
  logic [IDX_W:0]    far_sum;
  logic [IDX_W-1:0]  far_idx;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] twist_v;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr_a;
  logic [IDX_W-1:0]  ram_raddr_b;
  logic [WORD_W-1:0] ram_rdata_a;
  logic [WORD_W-1:0] ram_rdata_b;

  assign in_stall_o    = (state_q != S_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign random_word_o = out_data_q;

  // Shared LCG step for the seed fill
  assign lcg_next = WORD_W'(lcg_q * LCG_MUL) + WORD_W'(1);

  // Twist neighbor addresses, wrapped around the store
  assign next_idx = (cnt_q == IDX_LAST) ? '0 : cnt_q + IDX_W'(1);
  assign far_sum  = {1'b0, cnt_q} + (IDX_W+1)'(TWIST_OFFSET);
  assign far_idx  = (far_sum >= (IDX_W+1)'(STATE_WORDS)) ?
                    IDX_W'(far_sum - (IDX_W+1)'(STATE_WORDS)) : far_sum[IDX_W-1:0];

  // One twist step from the carried high bit and the two read words
  assign twist_y = {hi_bit_q, ram_rdata_a[WORD_W-2:0]};
  assign twist_v = ram_rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? MAT_A : '0);

  // Read addresses by sequencer state
  always_comb begin
    ram_raddr_a = word_idx_q;
    ram_raddr_b = far_idx;
    case (state_q)
      S_TWIST_PRIME:          ram_raddr_a = '0;
      S_TWIST_RD, S_TWIST_WR: ram_raddr_a = next_idx;
      default:                ram_raddr_a = word_idx_q;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    word_idx_d  = word_idx_q;
    load_ptr_d  = load_ptr_q;
    cnt_d       = cnt_q;
    lcg_d       = lcg_q;
    hi_word_d   = hi_word_q;
    hi_bit_d    = hi_bit_q;
    draw_pend_d = draw_pend_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = twist_v;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (cmd_i)
            CMD_RESEED: begin
              lcg_d       = seed_q;
              cnt_d       = '0;
              draw_pend_d = 1'b0;
              state_d     = S_SEED_HI;
            end
            CMD_LOAD: begin
              ram_we    = 1'b1;
              ram_waddr = load_ptr_q;
              ram_wdata = load_word_i;
              if (load_ptr_q == IDX_LAST) begin
                load_ptr_d = '0;
                word_idx_d = IDX_SPENT;
              end else begin
                load_ptr_d = load_ptr_q + IDX_W'(1);
              end
            end
            CMD_DRAW: begin
              if (word_idx_q == IDX_UNSEEDED) begin
                lcg_d       = DEFAULT_SEED;
                cnt_d       = '0;
                draw_pend_d = 1'b1;
                state_d     = S_SEED_HI;
              end else if (word_idx_q == IDX_SPENT) begin
                cnt_d   = '0;
                state_d = S_TWIST_PRIME;
              end else begin
                state_d = S_DRAW_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SEED_HI: begin
        hi_word_d = lcg_q & HALF_MASK;
        lcg_d     = lcg_next;
        state_d   = S_SEED_LO;
      end
      S_SEED_LO: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = hi_word_q | ((lcg_q & HALF_MASK) >> 16);
        lcg_d     = lcg_next;
        if (cnt_q == IDX_LAST) begin
          cnt_d      = '0;
          word_idx_d = IDX_SPENT;
          load_ptr_d = '0;
          state_d    = draw_pend_q ? S_TWIST_PRIME : S_IDLE;
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = S_SEED_HI;
        end
      end
      S_TWIST_PRIME: begin
        state_d = S_TWIST_RD;
      end
      S_TWIST_RD: begin
        // old word k arrived from the previous read of port A
        hi_bit_d = ram_rdata_a[WORD_W-1];
        state_d  = S_TWIST_WR;
      end
      S_TWIST_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = twist_v;
        if (cnt_q == IDX_LAST) begin
          cnt_d       = '0;
          word_idx_d  = '0;
          draw_pend_d = 1'b0;
          state_d     = S_DRAW_RD;
        end else begin
          cnt_d   = cnt_q + IDX_W'(1);
          state_d = S_TWIST_RD;
        end
      end
      S_DRAW_RD: begin
        state_d = S_DRAW_OUT;
      end
      S_DRAW_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_data_d  = temper(ram_rdata_a);
          out_valid_d = 1'b1;
          word_idx_d  = word_idx_q + IDX_W'(1);
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= DEFAULT_SEED;
      word_idx_q  <= IDX_UNSEEDED;
      load_ptr_q  <= '0;
      cnt_q       <= '0;
      draw_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_idx_q  <= word_idx_d;
      load_ptr_q  <= load_ptr_d;
      cnt_q       <= cnt_d;
      draw_pend_q <= draw_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lcg_q      <= lcg_d;
    hi_word_q  <= hi_word_d;
    hi_bit_q   <= hi_bit_d;
    out_data_q <= out_data_d;
  end

  // State word store
  mtg_ram #(
    .WIDTH(WORD_W),
    .DEPTH(STATE_WORDS)
  ) u_state_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  // Read index never passes the unseeded mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_idx_q <= IDX_UNSEEDED)
    else $error("word index out of range");

  // Load pointer stays inside the store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_ptr_q <= IDX_LAST)
    else $error("load pointer out of range");

  // Twisting only runs on a spent state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TWIST_RD || state_q == S_TWIST_WR) |-> word_idx_q == IDX_SPENT)
    else $error("twist with unspent state");

  // A new result only comes from the draw output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q && out_stall_i)) |-> $past(state_q == S_DRAW_OUT))
    else $error("result beat without a draw");

  // An armed draw never reads an index at or past the end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAW_RD) |-> word_idx_q < IDX_SPENT)
    else $error("draw read past end of state");

endmodule
